// ===== src/grid_warp_pixel_sampler_core_assert.svh =====
// assertion macros shared by the checker files
`ifndef GRID_WARP_PIXEL_SAMPLER_CORE_ASSERT_SVH
`define GRID_WARP_PIXEL_SAMPLER_CORE_ASSERT_SVH

// implication into the next cycle, off while reset is asserted
`define GWPS_CHK_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("gwps check failed");

// implication into the next cycle, live through reset
`define GWPS_CHK_ALWAYS(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error("gwps reset check failed");

`endif

// ===== src/gwps_pkg.sv =====
package gwps_pkg;

    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int MAX_GRID_COLS = 32;
    localparam int MAX_GRID_ROWS = 32;

    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int GRID_DEPTH  = MAX_GRID_COLS * MAX_GRID_ROWS;
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
    localparam int GRID_AW     = $clog2(GRID_DEPTH);

    // shared radix-2 divider: 32-bit dividend, 9-bit divisor
    localparam int DIV_STEPS = 32;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // request opcodes
    localparam logic [1:0] OP_GRID   = 2'd0;
    localparam logic [1:0] OP_PIXEL  = 2'd1;
    localparam logic [1:0] OP_RENDER = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_GRID_COLS    = 3'd2;
    localparam logic [2:0] CFG_GRID_ROWS    = 3'd3;
    localparam logic [2:0] CFG_SUBPIXEL     = 3'd4;
    localparam logic [2:0] CFG_WRAP         = 3'd5;
    localparam logic [2:0] CFG_BLEND        = 3'd6;

    typedef struct packed {
        logic [31:0] y;
        logic [31:0] x;
    } t_grid_pt;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [8:0]  den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [8:0]  rem;
    } t_div_rsp;

endpackage

// ===== src/gwps_divider.sv =====
module gwps_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gwps_pkg::t_div_req  i_req,
    output gwps_pkg::t_div_rsp  o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [gwps_pkg::DIV_CW-1:0] r_cnt;
    logic [31:0]                 r_q;
    logic [8:0]                  r_r;
    logic [8:0]                  r_den;
    logic [9:0]                  trial;
    logic [9:0]                  diff;
    logic                        ge;

    assign trial = {r_r, r_q[31]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == gwps_pkg::DIV_CW'(gwps_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.num;
            r_r   <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_r <= ge ? diff[8:0] : trial[8:0];
            r_q <= {r_q[30:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;

endmodule

// ===== src/gwps_frame_store.sv =====
module gwps_frame_store (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [gwps_pkg::FRAME_AW-1:0] i_waddr,
    input  logic [31:0]                   i_wdata,
    input  logic [gwps_pkg::FRAME_AW-1:0] i_raddr,
    output logic [31:0]                   o_rdata
);

    logic [31:0] r_mem [0:gwps_pkg::FRAME_DEPTH-1];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/gwps_grid_store.sv =====
module gwps_grid_store (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [gwps_pkg::GRID_AW-1:0] i_waddr,
    input  gwps_pkg::t_grid_pt           i_wdata,
    input  logic [gwps_pkg::GRID_AW-1:0] i_raddr,
    output gwps_pkg::t_grid_pt           o_rdata
);

    gwps_pkg::t_grid_pt r_mem [0:gwps_pkg::GRID_DEPTH-1];
    gwps_pkg::t_grid_pt r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/grid_warp_pixel_sampler_core.sv =====
// channel   direction  handshake                    payload
// request   in         i_in_valid / o_in_stall      opcode, grid point, pixel, render target
// result    out        o_out_valid / i_out_stall    o_out_pixel
// config    in         i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// grid and pixel writes leave the block idle; a plain copy render skips the divider
// a warped render makes eight passes through the shared radix-2 divider (ten with wrap)
// plus the segment search, one grid segment a cycle
// the source frame and the grid sit in synchronous memories with a separate write port, one read a cycle
// sync active-low reset clears the sequencer, divider, config and output valid flag only
// a finished result waits in the output register; the next request is taken meanwhile
module grid_warp_pixel_sampler_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_opcode,
    input  logic [9:0]          i_grid_index,
    input  logic signed [31:0]  i_point_src_x,
    input  logic signed [31:0]  i_point_src_y,
    input  logic [15:0]         i_pixel_address,
    input  logic [31:0]         i_pixel_value,
    input  logic [7:0]          i_dest_x,
    input  logic [7:0]          i_dest_y,
    input  logic [31:0]         i_prior_pixel,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [31:0]         o_out_pixel,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data
);

    // sequencer states
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DWAIT    = 5'd1;
    localparam logic [4:0] S_SEG_DIV  = 5'd2;
    localparam logic [4:0] S_SEG_INIT = 5'd3;
    localparam logic [4:0] S_SEG_RUN  = 5'd4;
    localparam logic [4:0] S_IDX      = 5'd5;
    localparam logic [4:0] S_GRD0     = 5'd6;
    localparam logic [4:0] S_GRD1     = 5'd7;
    localparam logic [4:0] S_GRD2     = 5'd8;
    localparam logic [4:0] S_GRD3     = 5'd9;
    localparam logic [4:0] S_GRD4     = 5'd10;
    localparam logic [4:0] S_LIN_DIV  = 5'd11;
    localparam logic [4:0] S_LIN_MUL  = 5'd12;
    localparam logic [4:0] S_LIN_ADD  = 5'd13;
    localparam logic [4:0] S_WRAP_DIV = 5'd14;
    localparam logic [4:0] S_WRAP_FIN = 5'd15;
    localparam logic [4:0] S_CLAMP    = 5'd16;
    localparam logic [4:0] S_SMP      = 5'd17;
    localparam logic [4:0] S_MUL      = 5'd18;
    localparam logic [4:0] S_RD0      = 5'd19;
    localparam logic [4:0] S_RD1      = 5'd20;
    localparam logic [4:0] S_RD2      = 5'd21;
    localparam logic [4:0] S_RD3      = 5'd22;
    localparam logic [4:0] S_RD4      = 5'd23;
    localparam logic [4:0] S_LERP1    = 5'd24;
    localparam logic [4:0] S_LERP2    = 5'd25;
    localparam logic [4:0] S_FIN      = 5'd26;

    localparam logic [8:0] W_MAX  = 9'(gwps_pkg::MAX_WIDTH);
    localparam logic [8:0] H_MAX  = 9'(gwps_pkg::MAX_HEIGHT);
    localparam logic [5:0] GC_MAX = 6'(gwps_pkg::MAX_GRID_COLS);
    localparam logic [5:0] GR_MAX = 6'(gwps_pkg::MAX_GRID_ROWS);

    // blend and interpolation helpers
    function automatic logic [7:0] mix8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] f);
        logic [16:0] s;
        s = 17'(a) * (17'd256 - 17'(f)) + 17'(b) * 17'(f);
        return s[15:8];
    endfunction

    function automatic logic [31:0] max_blend(input logic [31:0] a, input logic [31:0] b,
                                              input logic en);
        logic [31:0] r;
        r = a;
        for (int c = 0; c < 4; c++) begin
            if (en && (b[c*8 +: 8] > a[c*8 +: 8])) begin
                r[c*8 +: 8] = b[c*8 +: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [23:0] clamp_c(input logic [31:0] s, input logic [8:0] size);
        logic [23:0] lim;
        lim = {8'(size - 9'd1), 16'h0000};
        if (s[31]) begin
            return 24'd0;
        end else if (s > {8'h00, lim}) begin
            return lim;
        end else begin
            return s[23:0];
        end
    endfunction

    // configuration registers
    logic [8:0] r_cfg_width, r_cfg_height;
    logic [5:0] r_cfg_gcols, r_cfg_grows;
    logic       r_cfg_subpix, r_cfg_wrap, r_cfg_blend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= W_MAX;
            r_cfg_height <= H_MAX;
            r_cfg_gcols  <= '0;
            r_cfg_grows  <= '0;
            r_cfg_subpix <= 1'b0;
            r_cfg_wrap   <= 1'b0;
            r_cfg_blend  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gwps_pkg::CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data;
                gwps_pkg::CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data;
                gwps_pkg::CFG_GRID_COLS:    r_cfg_gcols  <= i_cfg_data[5:0];
                gwps_pkg::CFG_GRID_ROWS:    r_cfg_grows  <= i_cfg_data[5:0];
                gwps_pkg::CFG_SUBPIXEL:     r_cfg_subpix <= i_cfg_data[0];
                gwps_pkg::CFG_WRAP:         r_cfg_wrap   <= i_cfg_data[0];
                gwps_pkg::CFG_BLEND:        r_cfg_blend  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // saturated frame and grid sizes
    logic [8:0] w_sat, h_sat;
    logic [5:0] gc_sat, gr_sat;
    assign w_sat  = (r_cfg_width < 9'd2) ? 9'd2 :
                    ((r_cfg_width > W_MAX) ? W_MAX : r_cfg_width);
    assign h_sat  = (r_cfg_height < 9'd2) ? 9'd2 :
                    ((r_cfg_height > H_MAX) ? H_MAX : r_cfg_height);
    assign gc_sat = (r_cfg_gcols > GC_MAX) ? GC_MAX : r_cfg_gcols;
    assign gr_sat = (r_cfg_grows > GR_MAX) ? GR_MAX : r_cfg_grows;

    // control registers
    logic [4:0] r_state, n_state;
    logic [4:0] r_ret, n_ret;
    logic       r_out_valid;
    logic [31:0] r_out_pixel;

    // datapath registers
    logic [8:0]  r_w, r_h;
    logic [5:0]  r_gc, r_gr;
    logic [7:0]  r_dx, r_dy;
    logic [31:0] r_prior;
    logic        r_copy, r_sel;
    logic [24:0] r_step, r_acc;
    logic [8:0]  r_last;
    logic [4:0]  r_g, r_gy, r_gx;
    logic [7:0]  r_ys, r_xs;
    logic [8:0]  r_yl, r_xl;
    logic [9:0]  r_i0;
    gwps_pkg::t_grid_pt r_pt0, r_pt1, r_pt2, r_pt3;
    logic [2:0]  r_k;
    logic        r_neg;
    logic [31:0] r_prod;
    logic [31:0] r_lx, r_ly, r_rx, r_ry, r_sx, r_sy;
    logic [15:0] r_mag_lo;
    logic [23:0] r_cx, r_cy;
    logic [7:0]  r_x0, r_y0, r_fx, r_fy;
    logic [15:0] r_base;
    logic [31:0] r_p00, r_p01, r_p10, r_p11;
    logic [3:0][7:0] r_c0, r_c1;
    logic [31:0] r_res;

    // handshakes
    logic in_accept, out_free, render_go, copy_mode;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign copy_mode  = (gc_sat < 6'd2) || (gr_sat < 6'd2);
    assign render_go  = in_accept && (i_opcode == gwps_pkg::OP_RENDER) &&
                        ({1'b0, i_dest_x} < w_sat) && ({1'b0, i_dest_y} < h_sat);

    // stores
    logic                          frame_we, grid_we;
    logic [gwps_pkg::FRAME_AW-1:0] frame_raddr;
    logic [gwps_pkg::GRID_AW-1:0]  grid_raddr;
    logic [31:0]                   frame_rdata;
    gwps_pkg::t_grid_pt            grid_rdata, grid_wdata;

    assign frame_we     = in_accept && (i_opcode == gwps_pkg::OP_PIXEL);
    assign grid_we      = in_accept && (i_opcode == gwps_pkg::OP_GRID);
    assign grid_wdata.x = i_point_src_x;
    assign grid_wdata.y = i_point_src_y;

    gwps_frame_store u_frame (
        .i_clk   (i_clk),
        .i_we    (frame_we),
        .i_waddr (i_pixel_address),
        .i_wdata (i_pixel_value),
        .i_raddr (frame_raddr),
        .o_rdata (frame_rdata)
    );

    gwps_grid_store u_grid (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_waddr (i_grid_index),
        .i_wdata (grid_wdata),
        .i_raddr (grid_raddr),
        .o_rdata (grid_rdata)
    );

    // shared divider
    gwps_pkg::t_div_req div_req;
    gwps_pkg::t_div_rsp div_rsp;

    gwps_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // segment search: one boundary per cycle, rows first then columns
    logic [8:0]  seg_size, seg_end;
    logic [5:0]  seg_n;
    logic [7:0]  seg_pos;
    logic [24:0] seg_acc_n;
    logic        seg_last, seg_hit;
    assign seg_size  = r_sel ? r_w : r_h;
    assign seg_n     = r_sel ? r_gc : r_gr;
    assign seg_pos   = r_sel ? r_dx : r_dy;
    assign seg_acc_n = r_acc + r_step;
    assign seg_last  = ({1'b0, r_g} == (seg_n - 6'd2));
    assign seg_end   = seg_last ? seg_size : seg_acc_n[24:16];
    assign seg_hit   = ({1'b0, seg_pos} < seg_end);

    // edge and step interpolation, six passes selected by r_k:
    // left x, left y, right x, right y, then source x and y along the scanline
    logic [7:0]  row, col, lin_mul;
    logic [31:0] lin_diff, lin_base, lin_mag, lin_sum, quot_s;
    logic [8:0]  lin_den;
    assign row = r_dy - r_ys;
    assign col = r_dx - r_xs;

    always_comb begin
        unique case (r_k)
            3'd0: begin
                lin_diff = r_pt2.x - r_pt0.x;
                lin_base = r_pt0.x;
            end
            3'd1: begin
                lin_diff = r_pt2.y - r_pt0.y;
                lin_base = r_pt0.y;
            end
            3'd2: begin
                lin_diff = r_pt3.x - r_pt1.x;
                lin_base = r_pt1.x;
            end
            3'd3: begin
                lin_diff = r_pt3.y - r_pt1.y;
                lin_base = r_pt1.y;
            end
            3'd4: begin
                lin_diff = r_rx - r_lx;
                lin_base = r_lx;
            end
            default: begin
                lin_diff = r_ry - r_ly;
                lin_base = r_ly;
            end
        endcase
    end

    assign lin_den = (r_k < 3'd4) ? r_yl : r_xl;
    assign lin_mul = (r_k < 3'd4) ? row : col;
    assign lin_mag = lin_diff[31] ? (~lin_diff + 32'd1) : lin_diff;
    assign quot_s  = r_neg ? (~div_rsp.quot + 32'd1) : div_rsp.quot;
    assign lin_sum = lin_base + r_prod;

    // wrap: |v| mod (size<<16) from the integer part's remainder
    logic [31:0] wr_s, wr_mag;
    logic [8:0]  wr_size;
    logic [23:0] wr_mod, wr_res;
    logic [24:0] wr_m;
    assign wr_s    = r_k[0] ? r_sy : r_sx;
    assign wr_size = r_k[0] ? r_h : r_w;
    assign wr_mag  = wr_s[31] ? (~wr_s + 32'd1) : wr_s;
    assign wr_mod  = {div_rsp.rem[7:0], r_mag_lo};
    assign wr_m    = {wr_size, 16'h0000};
    assign wr_res  = !r_neg ? wr_mod :
                     ((wr_mod == 24'd0) ? 24'd0 : 24'(wr_m - {1'b0, wr_mod}));

    // sample position
    logic [7:0] bx0, by0, bfx, bfy, nx, ny;
    logic [8:0] nx9, ny9;
    always_comb begin
        bx0 = r_cx[23:16];
        bfx = r_cx[15:8];
        if ({1'b0, r_cx[23:16]} >= (r_w - 9'd1)) begin
            bx0 = 8'(r_w - 9'd2);
            bfx = 8'hFF;
        end
        by0 = r_cy[23:16];
        bfy = r_cy[15:8];
        if ({1'b0, r_cy[23:16]} >= (r_h - 9'd1)) begin
            by0 = 8'(r_h - 9'd2);
            bfy = 8'hFF;
        end
        nx9 = 9'((25'(r_cx) + 25'h0_8000) >> 16);
        ny9 = 9'((25'(r_cy) + 25'h0_8000) >> 16);
        nx  = (nx9 > (r_w - 9'd1)) ? 8'(r_w - 9'd1) : nx9[7:0];
        ny  = (ny9 > (r_h - 9'd1)) ? 8'(r_h - 9'd1) : ny9[7:0];
    end

    logic [31:0] lerp_px;
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            lerp_px[c*8 +: 8] = mix8(r_c0[c], r_c1[c], r_fy);
        end
    end

    logic [10:0] idx_prod;
    logic [16:0] base_prod;
    assign idx_prod  = 11'(r_gy) * 11'(r_gc);
    assign base_prod = 17'(r_y0) * 17'(r_w);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        div_req     = '0;
        frame_raddr = r_base + 16'(r_x0);
        grid_raddr  = r_i0;
        unique case (r_state)
            S_IDLE: begin
                if (render_go) begin
                    n_state = copy_mode ? S_MUL : S_SEG_DIV;
                end
            end
            S_DWAIT: begin
                if (div_rsp.done) begin
                    n_state = r_ret;
                end
            end
            S_SEG_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = {7'd0, seg_size, 16'h0000};
                div_req.den   = {3'd0, seg_n - 6'd1};
                n_ret         = S_SEG_INIT;
                n_state       = S_DWAIT;
            end
            S_SEG_INIT: n_state = S_SEG_RUN;
            S_SEG_RUN: begin
                if (seg_hit) begin
                    n_state = r_sel ? S_IDX : S_SEG_DIV;
                end
            end
            S_IDX:  n_state = S_GRD0;
            S_GRD0: n_state = S_GRD1;
            S_GRD1: begin
                grid_raddr = r_i0 + 10'd1;
                n_state    = S_GRD2;
            end
            S_GRD2: begin
                grid_raddr = r_i0 + 10'(r_gc);
                n_state    = S_GRD3;
            end
            S_GRD3: begin
                grid_raddr = r_i0 + 10'(r_gc) + 10'd1;
                n_state    = S_GRD4;
            end
            S_GRD4: n_state = S_LIN_DIV;
            S_LIN_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = lin_mag;
                div_req.den   = lin_den;
                n_ret         = S_LIN_MUL;
                n_state       = S_DWAIT;
            end
            S_LIN_MUL: n_state = S_LIN_ADD;
            S_LIN_ADD: begin
                if (r_k == 3'd5) begin
                    n_state = r_cfg_wrap ? S_WRAP_DIV : S_CLAMP;
                end else begin
                    n_state = S_LIN_DIV;
                end
            end
            S_WRAP_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = {16'h0000, wr_mag[31:16]};
                div_req.den   = wr_size;
                n_ret         = S_WRAP_FIN;
                n_state       = S_DWAIT;
            end
            S_WRAP_FIN: n_state = r_k[0] ? S_SMP : S_WRAP_DIV;
            S_CLAMP:    n_state = S_SMP;
            S_SMP:      n_state = S_MUL;
            S_MUL:      n_state = S_RD0;
            S_RD0:      n_state = S_RD1;
            S_RD1: begin
                frame_raddr = r_base + 16'(r_x0) + 16'd1;
                n_state     = (r_copy || !r_cfg_subpix) ? S_FIN : S_RD2;
            end
            S_RD2: begin
                frame_raddr = r_base + 16'(r_w) + 16'(r_x0);
                n_state     = S_RD3;
            end
            S_RD3: begin
                frame_raddr = r_base + 16'(r_w) + 16'(r_x0) + 16'd1;
                n_state     = S_RD4;
            end
            S_RD4:   n_state = S_LERP1;
            S_LERP1: n_state = S_LERP2;
            S_LERP2: n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (render_go) begin
                    r_w     <= w_sat;
                    r_h     <= h_sat;
                    r_gc    <= gc_sat;
                    r_gr    <= gr_sat;
                    r_dx    <= i_dest_x;
                    r_dy    <= i_dest_y;
                    r_prior <= i_prior_pixel;
                    r_copy  <= copy_mode;
                    r_sel   <= 1'b0;
                    r_x0    <= i_dest_x;
                    r_y0    <= i_dest_y;
                end
            end
            S_SEG_INIT: begin
                r_step <= div_rsp.quot[24:0];
                r_acc  <= '0;
                r_last <= '0;
                r_g    <= '0;
            end
            S_SEG_RUN: begin
                r_acc <= seg_acc_n;
                if (seg_hit) begin
                    if (!r_sel) begin
                        r_gy  <= r_g;
                        r_ys  <= r_last[7:0];
                        r_yl  <= seg_end - r_last;
                        r_sel <= 1'b1;
                    end else begin
                        r_gx <= r_g;
                        r_xs <= r_last[7:0];
                        r_xl <= seg_end - r_last;
                    end
                end else begin
                    r_last <= seg_end;
                    r_g    <= r_g + 5'd1;
                end
            end
            S_IDX:  r_i0  <= 10'(idx_prod + 11'(r_gx));
            S_GRD1: r_pt0 <= grid_rdata;
            S_GRD2: r_pt1 <= grid_rdata;
            S_GRD3: r_pt2 <= grid_rdata;
            S_GRD4: begin
                r_pt3 <= grid_rdata;
                r_k   <= 3'd0;
            end
            S_LIN_DIV: r_neg  <= lin_diff[31];
            S_LIN_MUL: r_prod <= quot_s * {24'd0, lin_mul};
            S_LIN_ADD: begin
                unique case (r_k)
                    3'd0:    r_lx <= lin_sum;
                    3'd1:    r_ly <= lin_sum;
                    3'd2:    r_rx <= lin_sum;
                    3'd3:    r_ry <= lin_sum;
                    3'd4:    r_sx <= lin_sum;
                    default: r_sy <= lin_sum;
                endcase
                r_k <= (r_k == 3'd5) ? 3'd0 : r_k + 3'd1;
            end
            S_WRAP_DIV: begin
                r_neg    <= wr_s[31];
                r_mag_lo <= wr_mag[15:0];
            end
            S_WRAP_FIN: begin
                if (r_k[0]) begin
                    r_cy <= wr_res;
                end else begin
                    r_cx <= wr_res;
                end
                r_k <= r_k + 3'd1;
            end
            S_CLAMP: begin
                r_cx <= clamp_c(r_sx, r_w);
                r_cy <= clamp_c(r_sy, r_h);
            end
            S_SMP: begin
                if (r_cfg_subpix) begin
                    r_x0 <= bx0;
                    r_y0 <= by0;
                    r_fx <= bfx;
                    r_fy <= bfy;
                end else begin
                    r_x0 <= nx;
                    r_y0 <= ny;
                end
            end
            S_MUL: r_base <= base_prod[15:0];
            S_RD1: begin
                // nearest and plain copy finish on the first read
                if (r_copy) begin
                    r_res <= frame_rdata;
                end else begin
                    r_res <= max_blend(frame_rdata, r_prior, r_cfg_blend);
                end
                r_p00 <= frame_rdata;
            end
            S_RD2: r_p01 <= frame_rdata;
            S_RD3: r_p10 <= frame_rdata;
            S_RD4: r_p11 <= frame_rdata;
            S_LERP1: begin
                for (int c = 0; c < 4; c++) begin
                    r_c0[c] <= mix8(r_p00[c*8 +: 8], r_p01[c*8 +: 8], r_fx);
                    r_c1[c] <= mix8(r_p10[c*8 +: 8], r_p11[c*8 +: 8], r_fx);
                end
            end
            S_LERP2: r_res <= max_blend(lerp_px, r_prior, r_cfg_blend);
            S_FIN: begin
                if (out_free) begin
                    r_out_pixel <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;

endmodule

// ===== src/gwps_checker.sv =====
`include "grid_warp_pixel_sampler_core_assert.svh"

module gwps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_opcode,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_out_pixel
);

    // a stalled result stays offered
    `GWPS_CHK_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    // and keeps its value
    `GWPS_CHK_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_pixel))
    // store writes and unused opcodes never hold off the next request
    `GWPS_CHK_NEXT(a_write_fast, i_in_valid && !o_in_stall && (i_opcode == gwps_pkg::OP_GRID || i_opcode == gwps_pkg::OP_PIXEL || i_opcode == gwps_pkg::OP_NONE), !o_in_stall)
    // reset leaves the block idle with nothing offered
    `GWPS_CHK_ALWAYS(a_reset_idle, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind grid_warp_pixel_sampler_core gwps_checker u_gwps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_opcode    (i_opcode),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_pixel (o_out_pixel)
);
